>>> rtl/ddq_pkg.sv
// shared types and constants for the bounded deque with value delete
package ddq_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_DELETE     = 2'd2,
		OP_READ_ALL   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  item_value;
		logic                      last;
	} result_t;

endpackage

>>> rtl/bounded_deque_with_value_delete.sv
// top level: bounded deque of signed values with push, delete by value and read out
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_ready    operation, value
//   out       source      out_valid / out_ready  status, item_value, last
//
// push front or back: accept, then result into the output register
// delete: the head is compared first, then the tail, then the middle entries are
//   scanned with one store read per cycle; on a middle match, one read plus one
//   write per cycle while later entries close the gap
// read out: one store read per emitted element
// reset clears head, count and the sequencer; the store itself is not cleared
// a stalled output holds the sequencer; in_ready is high only while idle
module bounded_deque_with_value_delete #(
	parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic signed [ddq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [ddq_pkg::DATA_W-1:0] item_value,
	output logic                              last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL_HEAD,
		S_DEL_TAIL,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [AW-1:0]                     head_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     pos_q;
	logic signed [ddq_pkg::DATA_W-1:0] val_q;
	ddq_pkg::status_t                  status_q;

	// store port signals
	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic signed [ddq_pkg::DATA_W-1:0] ram_wdata;
	logic                              ram_re;
	logic [AW-1:0]                     ram_raddr;
	logic signed [ddq_pkg::DATA_W-1:0] ram_rdata;

	// result path
	logic             res_load;
	ddq_pkg::result_t res_d;
	ddq_pkg::result_t res_q;
	logic             out_free;

	logic          in_fire;
	logic          full;
	logic          empty;
	logic          match;
	logic [CW:0]   pos_p1;
	logic [CW:0]   pos_p2;
	logic [CW:0]   count_x;
	logic [CW-1:0] count_m1;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	ddq_pkg::op_t  op;

	// store slot of list position p, p no larger than DEPTH
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
	                                          input logic [CW:0] p);
		logic [CW:0] s;
		s = (CW + 1)'(head) + p;
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[AW-1:0];
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign op       = ddq_pkg::op_t'(operation);
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign match    = (ram_rdata == val_q);
	assign pos_p1   = (CW + 1)'(pos_q) + (CW + 1)'(1);
	assign pos_p2   = (CW + 1)'(pos_q) + (CW + 1)'(2);
	assign count_x  = (CW + 1)'(count_q);
	assign count_m1 = count_q - CW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// store accesses and result loads per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = value;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		res_load  = 1'b0;
		res_d     = '{status: ddq_pkg::ST_OK, item_value: '0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (op)
						ddq_pkg::OP_PUSH_FRONT: begin
							ram_we    = !full;
							ram_waddr = head_dec;
						end
						ddq_pkg::OP_PUSH_BACK: begin
							ram_we    = !full;
							ram_waddr = slot_of(head_q, count_x);
						end
						ddq_pkg::OP_DELETE, ddq_pkg::OP_READ_ALL: begin
							// head read starts both the delete and the read out
							ram_re    = !empty;
							ram_raddr = head_q;
						end
						default: ;
					endcase
				end
			end
			S_DEL_HEAD: begin
				ram_re    = !match;
				ram_raddr = slot_of(head_q, (CW + 1)'(count_m1));
			end
			S_DEL_TAIL: begin
				ram_re    = !match && (count_q >= CW'(3));
				ram_raddr = slot_of(head_q, (CW + 1)'(1));
			end
			S_SCAN: begin
				// fetch the next entry; on a match it is the first one to move down
				ram_re    = 1'b1;
				ram_raddr = slot_of(head_q, pos_p1);
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_of(head_q, (CW + 1)'(pos_q));
				ram_wdata = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = slot_of(head_q, pos_p2);
			end
			S_READ: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_d     = '{status: ddq_pkg::ST_OK, item_value: ram_rdata,
					              last: (pos_p1 == count_x)};
					ram_re    = 1'b1;
					ram_raddr = slot_of(head_q, pos_p1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					res_d    = '{status: status_q, item_value: '0, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	// sequencer, list pointers and registered result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			status_q <= ddq_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						val_q <= value;
						unique case (op)
							ddq_pkg::OP_PUSH_FRONT, ddq_pkg::OP_PUSH_BACK: begin
								state_q <= S_DONE;
								if (full) begin
									status_q <= ddq_pkg::ST_FULL;
								end else begin
									status_q <= ddq_pkg::ST_OK;
									count_q  <= count_q + CW'(1);
									if (op == ddq_pkg::OP_PUSH_FRONT) begin
										head_q <= head_dec;
									end
								end
							end
							ddq_pkg::OP_DELETE: begin
								if (empty) begin
									status_q <= ddq_pkg::ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_DEL_HEAD;
								end
							end
							ddq_pkg::OP_READ_ALL: begin
								pos_q <= '0;
								if (empty) begin
									status_q <= ddq_pkg::ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: ;
						endcase
					end
				end
				S_DEL_HEAD: begin
					if (match) begin
						head_q   <= head_inc;
						count_q  <= count_m1;
						status_q <= ddq_pkg::ST_OK;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_DEL_TAIL;
					end
				end
				S_DEL_TAIL: begin
					if (match) begin
						count_q  <= count_m1;
						status_q <= ddq_pkg::ST_OK;
						state_q  <= S_DONE;
					end else if (count_q < CW'(3)) begin
						// no entry between head and tail
						status_q <= ddq_pkg::ST_NOTFOUND;
						state_q  <= S_DONE;
					end else begin
						pos_q   <= CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						state_q <= S_SHIFT;
					end else if (pos_p2 >= count_x) begin
						status_q <= ddq_pkg::ST_NOTFOUND;
						state_q  <= S_DONE;
					end else begin
						pos_q <= pos_p1[CW-1:0];
					end
				end
				S_SHIFT: begin
					if (pos_p2 == count_x) begin
						count_q  <= count_m1;
						status_q <= ddq_pkg::ST_OK;
						state_q  <= S_DONE;
					end else begin
						pos_q <= pos_p1[CW-1:0];
					end
				end
				S_READ: begin
					if (out_free) begin
						if (pos_p1 == count_x) begin
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_p1[CW-1:0];
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ddq_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ddq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.d         (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.q         (res_q),
		.free      (out_free)
	);

	assign status     = res_q.status;
	assign item_value = res_q.item_value;
	assign last       = res_q.last;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("element count above capacity");

	// while entries move down, the write never hits the entry being fetched
	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("store write and read at the same slot");

	// the element marked last ends the read out
	a_read_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && res_load && res_d.last) |=> (state_q == S_IDLE))
		else $error("read out continued past the tail");

	// a result is never loaded over one that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("pending result overwritten");

endmodule

>>> rtl/ddq_ram.sv
// element store: one write port, one read port, registered read data
module ddq_ram #(
	parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic signed [ddq_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic signed [ddq_pkg::DATA_W-1:0] rdata
);

	logic signed [ddq_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ddq_out.sv
// output register: holds one result until the consumer takes it
module ddq_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ddq_pkg::result_t  d,
	input  logic              out_ready,
	output logic              out_valid,
	output ddq_pkg::result_t  q,
	output logic              free
);

	logic             valid_q;
	ddq_pkg::result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule
